### rtl/door_motor_retry_controller_macros.svh
// assertion macros for the door motor retry controller
// no dependencies; included by the top level only
`ifndef DOOR_MOTOR_RETRY_CONTROLLER_MACROS_SVH
`define DOOR_MOTOR_RETRY_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define DMRC_ASSERT_HOLDS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("door controller check failed");

// antecedent implies consequent in the same cycle
`define DMRC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("door controller check failed");

`else

`define DMRC_ASSERT_HOLDS(label, clk, rst, cond)
`define DMRC_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

### rtl/dmrc_pkg.sv
// shared types and constants of the door motor retry controller
// no dependencies; used by every rtl module of the block
package dmrc_pkg;

  // controller states, numbered as reported on door_state
  typedef enum logic [4:0] {
    ST_INIT        = 5'd0,
    ST_CLOSING     = 5'd1,
    ST_CLOSE_STOP  = 5'd2,
    ST_CLOSED      = 5'd3,
    ST_OPENING     = 5'd4,
    ST_OPEN_STOP   = 5'd5,
    ST_OPEN        = 5'd6,
    ST_CLOSE_STALL = 5'd7,
    ST_CLOSE_BACK  = 5'd8,
    ST_CLOSE_RETRY = 5'd9,
    ST_BLOCKED     = 5'd10,
    ST_CLOSE_BLOCK = 5'd11,
    ST_OPEN_STALL  = 5'd12,
    ST_OPEN_BACK   = 5'd13,
    ST_OPEN_RETRY  = 5'd14,
    ST_OPEN_BLOCK  = 5'd15,
    ST_ALERT       = 5'd16,
    ST_SAGGED      = 5'd17
  } dmrc_state_t;

  // transition numbers
  typedef logic [4:0] dmrc_trans_t;
  localparam dmrc_trans_t TR_INIT           = 5'd0;
  localparam dmrc_trans_t TR_CLOSE_DONE     = 5'd1;
  localparam dmrc_trans_t TR_CLOSED_STOP    = 5'd2;
  localparam dmrc_trans_t TR_OPEN_REQ       = 5'd3;
  localparam dmrc_trans_t TR_OPEN_DONE      = 5'd4;
  localparam dmrc_trans_t TR_OPENED_STOP    = 5'd5;
  localparam dmrc_trans_t TR_CLOSE_REQ      = 5'd6;
  localparam dmrc_trans_t TR_CLOSE_FAIL     = 5'd7;
  localparam dmrc_trans_t TR_CLOSE_RETRY    = 5'd8;
  localparam dmrc_trans_t TR_BACK_OPENED    = 5'd9;
  localparam dmrc_trans_t TR_RETRY_CLOSED   = 5'd10;
  localparam dmrc_trans_t TR_CLOSE_GIVEUP   = 5'd11;
  localparam dmrc_trans_t TR_BACK_OPEN_FAIL = 5'd12;
  localparam dmrc_trans_t TR_BLOCK_ALERT    = 5'd13;
  localparam dmrc_trans_t TR_CLOSE_ALERT    = 5'd14;
  localparam dmrc_trans_t TR_OPEN_FAIL      = 5'd15;
  localparam dmrc_trans_t TR_OPEN_RETRY     = 5'd16;
  localparam dmrc_trans_t TR_BACK_OPEN      = 5'd17;
  localparam dmrc_trans_t TR_BACK_CLOSE     = 5'd18;
  localparam dmrc_trans_t TR_OPEN_GIVEUP    = 5'd19;
  localparam dmrc_trans_t TR_RETRY_OPENED   = 5'd20;
  localparam dmrc_trans_t TR_BACK_CLOSED    = 5'd21;
  localparam dmrc_trans_t TR_BACK_STUCK     = 5'd22;
  localparam dmrc_trans_t TR_OPEN_ALERT     = 5'd23;
  localparam dmrc_trans_t TR_ALERT_CLEAR    = 5'd24;
  localparam dmrc_trans_t TR_ALERT_REPEAT   = 5'd25;
  localparam dmrc_trans_t TR_SAG            = 5'd26;
  localparam dmrc_trans_t TR_REOPEN         = 5'd27;
  localparam dmrc_trans_t TR_NONE           = 5'd28;

  // motor drive codes
  localparam logic [1:0] MOT_STOP  = 2'd0;
  localparam logic [1:0] MOT_CLOSE = 2'd1;
  localparam logic [1:0] MOT_OPEN  = 2'd2;

  // timeout timer status
  localparam logic [1:0] TMR_IDLE = 2'd0;
  localparam logic [1:0] TMR_RUN  = 2'd1;
  localparam logic [1:0] TMR_DONE = 2'd2;

  // pending alert causes
  localparam logic [1:0] CAUSE_NONE        = 2'd0;
  localparam logic [1:0] CAUSE_BLOCKED     = 2'd1;
  localparam logic [1:0] CAUSE_CLOSE_BLOCK = 2'd2;
  localparam logic [1:0] CAUSE_OPEN_BLOCK  = 2'd3;

  // announcement codes; alert codes are ANN_ALERT plus the cause
  localparam logic [2:0] ANN_NONE   = 3'd0;
  localparam logic [2:0] ANN_START  = 3'd1;
  localparam logic [2:0] ANN_CLOSED = 3'd2;
  localparam logic [2:0] ANN_OPEN   = 3'd3;
  localparam logic [2:0] ANN_ALERT  = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_TO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MORN_LUX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EVEN_LUX  = 3'd4;

  localparam logic [1:0] MAX_ATTEMPTS = 2'd3;

  // configuration register contents
  typedef struct packed {
    logic [15:0] close_timeout_s;
    logic [15:0] open_timeout_s;
    logic [15:0] retry_pause_s;
    logic [15:0] morning_lux_min;
    logic [15:0] evening_lux_max;
  } dmrc_cfg_t;

  // one poll request
  typedef struct packed {
    logic        closed_switch;
    logic        open_switch;
    logic        open_button;
    logic        close_button;
    logic        reset_button;
    logic        is_morning;
    logic        is_evening;
    logic [15:0] lux;
    logic        second_tick;
  } dmrc_in_t;

  // controller context carried from poll to poll
  typedef struct packed {
    dmrc_state_t state;
    logic [1:0]  tmr_status;
    logic [15:0] tmr_left;
    logic [15:0] pause_left;
    logic [1:0]  close_att;
    logic [1:0]  open_att;
    logic [1:0]  cause;
    logic        lamp;
    logic [1:0]  motor;
  } dmrc_ctx_t;

  // one result
  typedef struct packed {
    logic [4:0]  door_state;
    logic [1:0]  motor_cmd;
    logic        alert_lamp;
    logic [2:0]  announce;
    dmrc_trans_t transition_taken;
  } dmrc_res_t;

endpackage

### rtl/dmrc_cfg.sv
// configuration register file of the door motor retry controller
// depends on dmrc_pkg
module dmrc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dmrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output dmrc_pkg::dmrc_cfg_t           regs
);
  import dmrc_pkg::*;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.close_timeout_s <= 16'd30;
      regs.open_timeout_s  <= 16'd30;
      regs.retry_pause_s   <= 16'd5;
      regs.morning_lux_min <= 16'd100;
      regs.evening_lux_max <= 16'd10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CLOSE_TO: regs.close_timeout_s <= cfg_data;
        REG_OPEN_TO:  regs.open_timeout_s  <= cfg_data;
        REG_PAUSE:    regs.retry_pause_s   <= cfg_data;
        REG_MORN_LUX: regs.morning_lux_min <= cfg_data;
        REG_EVEN_LUX: regs.evening_lux_max <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/dmrc_step.sv
// next-context and result logic for one poll of the door controller
// depends on dmrc_pkg
module dmrc_step (
  input  dmrc_pkg::dmrc_cfg_t cfg,
  input  dmrc_pkg::dmrc_ctx_t ctx,
  input  dmrc_pkg::dmrc_in_t  req,
  output dmrc_pkg::dmrc_ctx_t ctx_next,
  output dmrc_pkg::dmrc_res_t res
);
  import dmrc_pkg::*;

  // start the motor and timer for a retry attempt after the pause
  function automatic dmrc_ctx_t retry_start(dmrc_ctx_t c, dmrc_cfg_t g);
    dmrc_ctx_t r;
    r = c;
    r.tmr_status = TMR_RUN;
    if (c.state == ST_CLOSE_RETRY) begin
      r.tmr_left = g.close_timeout_s;
      r.motor    = MOT_CLOSE;
      if (c.close_att < MAX_ATTEMPTS) r.close_att = c.close_att + 2'd1;
    end else begin
      r.tmr_left = g.open_timeout_s;
      r.motor    = MOT_OPEN;
      if (c.open_att < MAX_ATTEMPTS) r.open_att = c.open_att + 2'd1;
    end
    return r;
  endfunction

  dmrc_ctx_t   nx;
  dmrc_trans_t tr;
  dmrc_state_t target;
  logic [2:0]  ann;
  logic        to;
  logic        nto;
  logic        open_cond;
  logic        close_cond;

  assign open_cond  = req.open_button || (req.is_morning && (req.lux > cfg.morning_lux_min));
  assign close_cond = req.close_button || (req.is_evening && (req.lux < cfg.evening_lux_max));

  always_comb begin
    nx     = ctx;
    tr     = TR_NONE;
    target = ctx.state;
    ann    = ANN_NONE;

    // timeout timer advances on the tick
    if (req.second_tick && (ctx.tmr_status == TMR_RUN)) begin
      if (ctx.tmr_left <= 16'd1) begin
        nx.tmr_left   = '0;
        nx.tmr_status = TMR_DONE;
      end else begin
        nx.tmr_left = ctx.tmr_left - 16'd1;
      end
    end

    to  = (nx.tmr_status == TMR_DONE);
    nto = !to;

    if (ctx.pause_left != '0) begin
      // retry pause counts down; no transition is tested
      if (req.second_tick) begin
        nx.pause_left = ctx.pause_left - 16'd1;
        if (nx.pause_left == '0) nx = retry_start(nx, cfg);
      end
    end else begin
      // first true transition of the current state
      case (ctx.state)
        ST_INIT: begin
          tr = TR_INIT; target = ST_CLOSING;
        end
        ST_CLOSING: begin
          if (req.closed_switch && nto) begin
            tr = TR_CLOSE_DONE; target = ST_CLOSE_STOP;
          end else if (to && !req.closed_switch) begin
            tr = TR_CLOSE_FAIL; target = ST_CLOSE_STALL;
          end
        end
        ST_CLOSE_STOP: begin
          tr = TR_CLOSED_STOP; target = ST_CLOSED;
        end
        ST_CLOSED: begin
          if (open_cond) begin
            tr = TR_OPEN_REQ; target = ST_OPENING;
          end
        end
        ST_OPENING: begin
          if (req.open_switch && nto) begin
            tr = TR_OPEN_DONE; target = ST_OPEN_STOP;
          end else if (to && !req.open_switch) begin
            tr = TR_OPEN_FAIL; target = ST_OPEN_STALL;
          end
        end
        ST_OPEN_STOP: begin
          tr = TR_OPENED_STOP; target = ST_OPEN;
        end
        ST_OPEN: begin
          if (close_cond) begin
            tr = TR_CLOSE_REQ; target = ST_CLOSING;
          end else if (!req.open_switch) begin
            tr = TR_SAG; target = ST_SAGGED;
          end
        end
        ST_CLOSE_STALL: begin
          tr = TR_BACK_OPEN; target = ST_CLOSE_BACK;
        end
        ST_CLOSE_BACK: begin
          if (req.open_switch && nto) begin
            tr = TR_BACK_OPENED; target = ST_CLOSE_RETRY;
          end else if (to && !req.open_switch) begin
            tr = TR_BACK_OPEN_FAIL; target = ST_BLOCKED;
          end
        end
        ST_CLOSE_RETRY: begin
          if (to && !req.closed_switch && (ctx.close_att < MAX_ATTEMPTS)) begin
            tr = TR_CLOSE_RETRY; target = ST_CLOSE_STALL;
          end else if (req.closed_switch && nto) begin
            tr = TR_RETRY_CLOSED; target = ST_CLOSE_STOP;
          end else if (to && !req.closed_switch && (ctx.close_att == MAX_ATTEMPTS)) begin
            tr = TR_CLOSE_GIVEUP; target = ST_CLOSE_BLOCK;
          end
        end
        ST_BLOCKED: begin
          tr = TR_BLOCK_ALERT; target = ST_ALERT;
        end
        ST_CLOSE_BLOCK: begin
          tr = TR_CLOSE_ALERT; target = ST_ALERT;
        end
        ST_OPEN_STALL: begin
          tr = TR_BACK_CLOSE; target = ST_OPEN_BACK;
        end
        ST_OPEN_BACK: begin
          if (req.closed_switch && nto) begin
            tr = TR_BACK_CLOSED; target = ST_OPEN_RETRY;
          end else if (to && !req.closed_switch) begin
            tr = TR_BACK_STUCK; target = ST_BLOCKED;
          end
        end
        ST_OPEN_RETRY: begin
          if (to && !req.open_switch && (ctx.open_att < MAX_ATTEMPTS)) begin
            tr = TR_OPEN_RETRY; target = ST_OPEN_STALL;
          end else if (to && !req.open_switch && (ctx.open_att == MAX_ATTEMPTS)) begin
            tr = TR_OPEN_GIVEUP; target = ST_OPEN_BLOCK;
          end else if (req.open_switch && nto) begin
            tr = TR_RETRY_OPENED; target = ST_OPEN_STOP;
          end
        end
        ST_OPEN_BLOCK: begin
          tr = TR_OPEN_ALERT; target = ST_ALERT;
        end
        ST_ALERT: begin
          if (req.reset_button) begin
            tr = TR_ALERT_CLEAR; target = ST_INIT;
          end else if (req.open_button) begin
            tr = TR_ALERT_REPEAT; target = ST_ALERT;
          end
        end
        ST_SAGGED: begin
          tr = TR_REOPEN; target = ST_OPENING;
        end
        default: ;
      endcase

      // entry actions of the target state
      if (tr != TR_NONE) begin
        nx.state = target;
        case (target)
          ST_INIT: begin
            nx.lamp       = 1'b0;
            nx.open_att   = '0;
            nx.close_att  = '0;
            nx.cause      = CAUSE_NONE;
            nx.motor      = MOT_STOP;
            nx.pause_left = '0;
            if (nx.tmr_status == TMR_RUN) nx.tmr_status = TMR_IDLE;
            ann = ANN_START;
          end
          ST_CLOSING: begin
            nx.tmr_left   = cfg.close_timeout_s;
            nx.tmr_status = TMR_RUN;
            nx.motor      = MOT_CLOSE;
            nx.close_att  = 2'd1;
          end
          ST_CLOSED: ann = ANN_CLOSED;
          ST_OPENING: begin
            nx.tmr_left   = cfg.open_timeout_s;
            nx.tmr_status = TMR_RUN;
            nx.motor      = MOT_OPEN;
            nx.open_att   = 2'd1;
          end
          ST_OPEN: ann = ANN_OPEN;
          ST_CLOSE_BACK: begin
            nx.tmr_left   = cfg.open_timeout_s;
            nx.tmr_status = TMR_RUN;
            nx.motor      = MOT_OPEN;
          end
          ST_OPEN_BACK: begin
            nx.tmr_left   = cfg.close_timeout_s;
            nx.tmr_status = TMR_RUN;
            nx.motor      = MOT_CLOSE;
          end
          ST_CLOSE_RETRY, ST_OPEN_RETRY: begin
            nx.motor      = MOT_STOP;
            nx.pause_left = cfg.retry_pause_s;
            if (cfg.retry_pause_s == '0) nx = retry_start(nx, cfg);
          end
          ST_BLOCKED, ST_CLOSE_BLOCK, ST_OPEN_BLOCK: begin
            if (target == ST_BLOCKED) nx.cause = CAUSE_BLOCKED;
            else if (target == ST_CLOSE_BLOCK) nx.cause = CAUSE_CLOSE_BLOCK;
            else nx.cause = CAUSE_OPEN_BLOCK;
            if (nx.tmr_status == TMR_RUN) nx.tmr_status = TMR_IDLE;
            nx.motor = MOT_STOP;
          end
          ST_CLOSE_STOP, ST_OPEN_STOP, ST_CLOSE_STALL, ST_OPEN_STALL: begin
            if (nx.tmr_status == TMR_RUN) nx.tmr_status = TMR_IDLE;
            nx.motor = MOT_STOP;
          end
          ST_ALERT: begin
            nx.lamp = 1'b1;
            ann     = ANN_ALERT | {1'b0, nx.cause};
          end
          default: ;
        endcase
      end
    end
  end

  assign ctx_next             = nx;
  assign res.door_state       = nx.state;
  assign res.motor_cmd        = nx.motor;
  assign res.alert_lamp       = nx.lamp;
  assign res.announce         = ann;
  assign res.transition_taken = tr;

endmodule

### rtl/door_motor_retry_controller.sv
// top level of the door motor retry controller: poll register, step logic,
// result register and controller context; needs dmrc_pkg, dmrc_cfg, dmrc_step
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  poll    | in        | in_valid/in_ready    | switches, buttons, flags, lux, tick
//  result  | out       | out_valid/out_ready  | door_state, motor_cmd, alert_lamp,
//          |           |                      | announce, transition_taken
//
// a poll is first held in the poll register, then the step logic updates
// the context and loads the result register; one poll per cycle sustained
// while out_ready is high. reset clears the valid flags, configuration and
// context only. a stalled result holds the poll register, and in_ready
// drops only when both registers are full and out_ready is low.
`include "door_motor_retry_controller_macros.svh"

module door_motor_retry_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dmrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           closed_switch,
  input  logic                           open_switch,
  input  logic                           open_button,
  input  logic                           close_button,
  input  logic                           reset_button,
  input  logic                           is_morning,
  input  logic                           is_evening,
  input  logic [15:0]                    lux,
  input  logic                           second_tick,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [4:0]                     door_state,
  output logic [1:0]                     motor_cmd,
  output logic                           alert_lamp,
  output logic [2:0]                     announce,
  output logic [4:0]                     transition_taken
);
  import dmrc_pkg::*;

  dmrc_cfg_t cfg;
  dmrc_in_t  req;
  logic      req_valid;
  dmrc_ctx_t ctx;
  dmrc_ctx_t ctx_next;
  dmrc_res_t res;
  dmrc_res_t res_q;
  logic      advance;

  // configuration registers
  dmrc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (cfg)
  );

  // poll logic
  dmrc_step u_step (
    .cfg      (cfg),
    .ctx      (ctx),
    .req      (req),
    .ctx_next (ctx_next),
    .res      (res)
  );

  // handshake: the held poll moves on when the result register frees up
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  // poll register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.closed_switch <= closed_switch;
      req.open_switch   <= open_switch;
      req.open_button   <= open_button;
      req.close_button  <= close_button;
      req.reset_button  <= reset_button;
      req.is_morning    <= is_morning;
      req.is_evening    <= is_evening;
      req.lux           <= lux;
      req.second_tick   <= second_tick;
    end
  end

  // controller context
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state      <= ST_INIT;
      ctx.tmr_status <= TMR_IDLE;
      ctx.tmr_left   <= '0;
      ctx.pause_left <= '0;
      ctx.close_att  <= '0;
      ctx.open_att   <= '0;
      ctx.cause      <= CAUSE_NONE;
      ctx.lamp       <= 1'b0;
      ctx.motor      <= MOT_STOP;
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign door_state       = res_q.door_state;
  assign motor_cmd        = res_q.motor_cmd;
  assign alert_lamp       = res_q.alert_lamp;
  assign announce         = res_q.announce;
  assign transition_taken = res_q.transition_taken;

  // checks
  `DMRC_ASSERT_IMPLIES(a_lamp_alert, clk, rst, out_valid, alert_lamp == (door_state == ST_ALERT))
  `DMRC_ASSERT_IMPLIES(a_ann_fired, clk, rst, out_valid && (announce != ANN_NONE),
                       transition_taken != TR_NONE)
  `DMRC_ASSERT_IMPLIES(a_ann_alert, clk, rst, out_valid && announce[2], door_state == ST_ALERT)
  `DMRC_ASSERT_IMPLIES(a_pause_stop, clk, rst, ctx.pause_left != '0, ctx.motor == MOT_STOP)

endmodule
